### hdl/mrptb_pkg.sv
// Package with the types, constants and helper functions of the timer bank.
package mrptb_pkg;

  localparam int TIER_STRIDE  = 8;
  localparam int FAST_SLOTS   = 8;
  localparam int MID_SLOTS    = 8;
  localparam int SLOW_SLOTS   = 8;
  localparam int PRESCALE_DIV = 10;

  localparam int SLOT_W   = $clog2(TIER_STRIDE);
  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 17;
  localparam int PRE_W    = 4;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_REG   = 2'd1;
  localparam logic [1:0] REQ_UNREG = 2'd2;

  localparam logic [1:0] TIER_FAST = 2'd0;
  localparam logic [1:0] TIER_MID  = 2'd1;
  localparam logic [1:0] TIER_SLOW = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [PRE_W-1:0] PRESCALE_LAST = PRE_W'(PRESCALE_DIV - 1);

  typedef struct packed {
    logic [1:0]          req_type;
    logic [1:0]          tier;
    logic [PERIOD_W-1:0] period;
    logic [2:0]          slot;
  } in_t;

  typedef struct packed {
    logic       status;
    logic [2:0] slot_given;
    logic [7:0] fired_fast;
    logic [7:0] fired_mid;
    logic [7:0] fired_slow;
  } out_t;

  // Commands from the top level to one tier.
  typedef struct packed {
    logic                advance;
    logic                claim;
    logic                release_en;
    logic [SLOT_W-1:0]   release_slot;
    logic [PERIOD_W-1:0] period;
  } tier_ctl_t;

  // Status from one tier back to the top level.
  typedef struct packed {
    logic [TIER_STRIDE-1:0] fired;
    logic                   has_free;
    logic [SLOT_W-1:0]      free_slot;
  } tier_stat_t;

  // Mask of the slots that exist in a tier of n slots.
  function automatic logic [TIER_STRIDE-1:0] slot_mask(input int n);
    logic [TIER_STRIDE-1:0] m;
    m = '0;
    for (int i = 0; i < TIER_STRIDE; i++) begin
      m[i] = (i < n);
    end
    return m;
  endfunction

endpackage

### hdl/multi_rate_periodic_timer_bank_unit.sv
// Top level of the three-tier periodic timer bank with cascaded prescalers.
// An accepted transaction is registered in in_r, then its result in out_r and
// on out_valid. Throughput: one transaction per cycle; busy stays low.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset (synchronous, rst_n low) clears both prescalers and frees every slot;
// periods and counts are loaded when a slot is claimed.
module multi_rate_periodic_timer_bank_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  mrptb_pkg::in_t  in_data,
  output logic            out_valid,
  output mrptb_pkg::out_t out_data
);
  import mrptb_pkg::*;

  logic            in_valid_r;
  in_t             in_r;
  logic            out_valid_r;
  out_t            out_r;
  out_t            out_nxt;
  logic [PRE_W-1:0] first_prescale_r, first_prescale_nxt;
  logic [PRE_W-1:0] second_prescale_r, second_prescale_nxt;

  logic       is_tick, is_reg, is_unreg;
  logic       mid_adv, slow_adv;
  tier_ctl_t  ctl  [3];
  tier_stat_t stat [3];
  logic       sel_free;
  logic [SLOT_W-1:0] sel_slot;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
  end

  assign is_tick  = in_valid_r && (in_r.req_type == REQ_TICK);
  assign is_reg   = in_valid_r && (in_r.req_type == REQ_REG);
  assign is_unreg = in_valid_r && (in_r.req_type == REQ_UNREG);

  // Cascaded divide-by-ten prescalers.
  always_comb begin
    first_prescale_nxt  = first_prescale_r;
    second_prescale_nxt = second_prescale_r;
    mid_adv             = 1'b0;
    slow_adv            = 1'b0;
    if (is_tick) begin
      if (first_prescale_r >= PRESCALE_LAST) begin
        first_prescale_nxt = '0;
        mid_adv            = 1'b1;
        if (second_prescale_r >= PRESCALE_LAST) begin
          second_prescale_nxt = '0;
          slow_adv            = 1'b1;
        end else begin
          second_prescale_nxt = second_prescale_r + PRE_W'(1);
        end
      end else begin
        first_prescale_nxt = first_prescale_r + PRE_W'(1);
      end
    end
  end

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      ctl[t].claim        = is_reg && (in_r.tier == 2'(t));
      ctl[t].release_en   = is_unreg && (in_r.tier == 2'(t));
      ctl[t].release_slot = in_r.slot;
      ctl[t].period       = in_r.period;
    end
    ctl[0].advance = is_tick;
    ctl[1].advance = mid_adv;
    ctl[2].advance = slow_adv;
  end

  mrptb_tier u_fast (
    .clk     (clk),
    .rst_n   (rst_n),
    .slot_en (slot_mask(FAST_SLOTS)),
    .ctl     (ctl[0]),
    .stat    (stat[0])
  );

  mrptb_tier u_mid (
    .clk     (clk),
    .rst_n   (rst_n),
    .slot_en (slot_mask(MID_SLOTS)),
    .ctl     (ctl[1]),
    .stat    (stat[1])
  );

  mrptb_tier u_slow (
    .clk     (clk),
    .rst_n   (rst_n),
    .slot_en (slot_mask(SLOW_SLOTS)),
    .ctl     (ctl[2]),
    .stat    (stat[2])
  );

  always_comb begin
    case (in_r.tier)
      TIER_FAST: begin
        sel_free = stat[0].has_free;
        sel_slot = stat[0].free_slot;
      end
      TIER_MID: begin
        sel_free = stat[1].has_free;
        sel_slot = stat[1].free_slot;
      end
      TIER_SLOW: begin
        sel_free = stat[2].has_free;
        sel_slot = stat[2].free_slot;
      end
      default: begin
        sel_free = 1'b0;
        sel_slot = '0;
      end
    endcase
  end

  always_comb begin
    out_nxt            = '0;
    out_nxt.fired_fast = stat[0].fired;
    out_nxt.fired_mid  = stat[1].fired;
    out_nxt.fired_slow = stat[2].fired;
    if (is_reg) begin
      if (sel_free) begin
        out_nxt.status     = STATUS_OK;
        out_nxt.slot_given = sel_slot;
      end else begin
        out_nxt.status = STATUS_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r       <= 1'b0;
      first_prescale_r  <= '0;
      second_prescale_r <= '0;
    end else begin
      out_valid_r       <= in_valid_r;
      first_prescale_r  <= first_prescale_nxt;
      second_prescale_r <= second_prescale_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Every accepted transaction produces exactly one result on out_valid.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted transaction produced no result");

  // Fired masks can only appear on the result of a tick.
  a_fired_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_data.fired_fast != '0) || (out_data.fired_mid != '0) ||
                   (out_data.fired_slow != '0)))
      |-> ($past(in_r.req_type) == REQ_TICK))
    else $error("fired mask on a non-tick result");

  // The slow tier only advances together with the mid tier.
  a_slow_needs_mid: assert property (@(posedge clk) disable iff (!rst_n)
    slow_adv |-> mid_adv)
    else $error("slow tier advanced without mid tier");

  // A mid advance wraps the first prescaler.
  a_prescale_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    mid_adv |=> (first_prescale_r == '0))
    else $error("first prescaler did not wrap");

  // A full status never carries a slot number.
  a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STATUS_FULL)) |-> (out_data.slot_given == '0))
    else $error("full status with a slot number");

endmodule

### hdl/mrptb_tier.sv
// One tier of timer slots: activity flags, periods, counters and free-slot search.
module mrptb_tier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mrptb_pkg::TIER_STRIDE-1:0]   slot_en,
  input  mrptb_pkg::tier_ctl_t                ctl,
  output mrptb_pkg::tier_stat_t               stat
);
  import mrptb_pkg::*;

  logic [TIER_STRIDE-1:0] slot_active_r;
  logic [PERIOD_W-1:0]    slot_period_r [TIER_STRIDE];
  logic [COUNT_W-1:0]     slot_count_r  [TIER_STRIDE];

  logic [TIER_STRIDE-1:0] expired;
  logic                   found;
  logic [SLOT_W-1:0]      free_idx;

  always_comb begin
    for (int s = 0; s < TIER_STRIDE; s++) begin
      expired[s] = slot_en[s] && slot_active_r[s] &&
                   (slot_count_r[s] > {1'b0, slot_period_r[s]});
    end
  end

  // Priority encoder for the lowest free slot.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int s = 0; s < TIER_STRIDE; s++) begin
      if (!found && slot_en[s] && !slot_active_r[s]) begin
        found    = 1'b1;
        free_idx = SLOT_W'(s);
      end
    end
  end

  assign stat.fired     = ctl.advance ? expired : '0;
  assign stat.has_free  = found;
  assign stat.free_slot = free_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_active_r <= '0;
    end else begin
      if (ctl.claim && found) begin
        slot_active_r[free_idx] <= 1'b1;
      end
      if (ctl.release_en && slot_en[ctl.release_slot]) begin
        slot_active_r[ctl.release_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < TIER_STRIDE; s++) begin
      if (ctl.claim && found && (free_idx == SLOT_W'(s))) begin
        slot_period_r[s] <= ctl.period;
        slot_count_r[s]  <= '0;
      end else if (ctl.advance && slot_en[s] && slot_active_r[s]) begin
        if (expired[s]) begin
          slot_count_r[s] <= '0;
        end else begin
          slot_count_r[s] <= slot_count_r[s] + COUNT_W'(1);
        end
      end
    end
  end

endmodule
